[sv/fbct_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Frustum box cull package
// Shared constants, item codes and result codes of the frustum box cull unit.
// ---------------------------------------------------------------------------
package fbct_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 48;
   localparam int NUM_PLANES          = 6;
   localparam int NUM_TESTS           = 2 * NUM_PLANES;
   localparam int RSP_DATA_WIDTH      = 8;

   // item kind carried in tuser
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_BOX  = 1'b1;

   // matrix columns that feed the planes
   localparam logic [1:0] COL_X = 2'd0;
   localparam logic [1:0] COL_Y = 2'd1;
   localparam logic [1:0] COL_W = 2'd3;

   typedef enum logic [1:0] {
      VERDICT_INSIDE    = 2'd0,
      VERDICT_INTERSECT = 2'd1,
      VERDICT_OUTSIDE   = 2'd2
   } verdict_type;

endpackage
`default_nettype wire

[sv/frustum_box_cull_test_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A box item gives its verdict on rsp_tvalid after the front, product, join, sign and verdict registers.
// Throughput: one item per cycle while rsp_tready holds; the five register stages advance independently.
// A load item writes its entry at acceptance and is seen by the next box item.
// Load items give no result and do not occupy the pipeline.
// Reset clears all matrix entries to zero and empties every stage.
// ---------------------------------------------------------------------------
// Frustum box cull test unit
// Loads a view-projection matrix one entry per item and classifies flat
// boxes against its six frustum planes as inside, intersecting or outside.
// ---------------------------------------------------------------------------
module frustum_box_cull_test_unit #(
   parameter int VALUE_WIDTH = fbct_pkg::VALUE_WIDTH_DEFAULT,
   localparam int REQ_FIELDS_WIDTH = 4 + 5 * VALUE_WIDTH,
   localparam int REQ_DATA_WIDTH   = ((REQ_FIELDS_WIDTH + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // column, row, value, min_x, min_y, max_x, max_y
   input  logic [REQ_DATA_WIDTH-1:0]           req_tdata,
   // kind
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // verdict
   output logic [fbct_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int CW   = VALUE_WIDTH + 1;
   localparam int FRAC = VALUE_WIDTH / 2;
   localparam int HW   = VALUE_WIDTH - FRAC;
   localparam int PHW  = CW + HW;
   localparam int PLW  = CW + FRAC + 1;
   localparam int W    = VALUE_WIDTH;

   logic req_fire;
   logic [1:0] req_column, req_row;
   logic signed [W-1:0] req_value, req_min_x, req_min_y, req_max_x, req_max_y;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic ready1, ready2, ready3, ready4, ready5;

   logic signed [W-1:0]  lo_x, lo_y, hi_x, hi_y;
   logic signed [CW-1:0] nx [fbct_pkg::NUM_PLANES];
   logic signed [CW-1:0] ny [fbct_pkg::NUM_PLANES];
   logic signed [CW-1:0] plane_d1 [fbct_pkg::NUM_PLANES];
   logic signed [CW-1:0] plane_d2 [fbct_pkg::NUM_PLANES];
   logic signed [PHW-1:0] xh [fbct_pkg::NUM_TESTS];
   logic signed [PLW-1:0] xl [fbct_pkg::NUM_TESTS];
   logic signed [PHW-1:0] yh [fbct_pkg::NUM_TESTS];
   logic signed [PLW-1:0] yl [fbct_pkg::NUM_TESTS];
   logic [fbct_pkg::NUM_TESTS-1:0] neg;
   logic [fbct_pkg::NUM_PLANES-1:0] p_neg, n_neg;

   fbct_pkg::verdict_type verdict_in, verdict_ff;

   assign req_column = req_tdata[1:0];
   assign req_row    = req_tdata[3:2];
   assign req_value  = $signed(req_tdata[4 + W - 1:4]);
   assign req_min_x  = $signed(req_tdata[4 + 2*W - 1:4 + W]);
   assign req_min_y  = $signed(req_tdata[4 + 3*W - 1:4 + 2*W]);
   assign req_max_x  = $signed(req_tdata[4 + 4*W - 1:4 + 3*W]);
   assign req_max_y  = $signed(req_tdata[4 + 5*W - 1:4 + 4*W]);

   // a stage takes new data when it is empty or its contents move on
   assign ready5 = !v5_ff || rsp_tready;
   assign ready4 = !v4_ff || ready5;
   assign ready3 = !v3_ff || ready4;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;

   assign req_tready = ready1;
   assign req_fire   = req_tvalid && req_tready;

   assign v1_in = ready1 ? (req_fire && (req_tuser == fbct_pkg::KIND_BOX)) : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;
   assign v3_in = ready3 ? v2_ff : v3_ff;
   assign v4_in = ready4 ? v3_ff : v4_ff;
   assign v5_in = ready5 ? v4_ff : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   fbct_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .load_en     (req_fire && (req_tuser == fbct_pkg::KIND_LOAD)),
      .load_column (req_column),
      .load_row    (req_row),
      .load_value  (req_value),
      .advance     (ready1),
      .box_min_x   (req_min_x),
      .box_min_y   (req_min_y),
      .box_max_x   (req_max_x),
      .box_max_y   (req_max_y),
      .lo_x        (lo_x),
      .lo_y        (lo_y),
      .hi_x        (hi_x),
      .hi_y        (hi_y),
      .nx          (nx),
      .ny          (ny),
      .plane_d     (plane_d1)
   );

   fbct_mult #(.VALUE_WIDTH(VALUE_WIDTH)) u_mult (
      .clock       (clock),
      .advance     (ready2),
      .lo_x        (lo_x),
      .lo_y        (lo_y),
      .hi_x        (hi_x),
      .hi_y        (hi_y),
      .nx          (nx),
      .ny          (ny),
      .plane_d     (plane_d1),
      .xh          (xh),
      .xl          (xl),
      .yh          (yh),
      .yl          (yl),
      .plane_d_out (plane_d2)
   );

   fbct_sum #(.VALUE_WIDTH(VALUE_WIDTH)) u_sum (
      .clock        (clock),
      .advance_join (ready3),
      .advance_sign (ready4),
      .xh           (xh),
      .xl           (xl),
      .yh           (yh),
      .yl           (yl),
      .plane_d      (plane_d2),
      .neg          (neg)
   );

   always_comb begin
      for (int k = 0; k < fbct_pkg::NUM_PLANES; k++) begin
         p_neg[k] = neg[2*k];
         n_neg[k] = neg[2*k+1];
      end
      if (|p_neg) begin
         verdict_in = fbct_pkg::VERDICT_OUTSIDE;
      end else if (|n_neg) begin
         verdict_in = fbct_pkg::VERDICT_INTERSECT;
      end else begin
         verdict_in = fbct_pkg::VERDICT_INSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (ready5) begin
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_tvalid = v5_ff;
   assign rsp_tdata  = {{(fbct_pkg::RSP_DATA_WIDTH - 2){1'b0}}, verdict_ff};

   a_load_no_slot: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_tuser == fbct_pkg::KIND_LOAD) |=> !v1_ff)
      else $error("load item entered the pipeline");

   a_outside_wins: assert property (@(posedge clock) disable iff (reset)
      v4_ff && ready5 && (|p_neg) |=> rsp_tdata[1:0] == fbct_pkg::VERDICT_OUTSIDE)
      else $error("failed p-vertex test did not give outside");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      v4_ff && !ready4 |=> v4_ff)
      else $error("stalled item dropped from sign stage");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !v4_ff |=> !rsp_tvalid)
      else $error("result repeated after it was taken");

endmodule
`default_nettype wire

[sv/fbct_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Frustum box cull front stage
// Holds the matrix entries, derives the six planes and registers them with
// the box of each item.
// ---------------------------------------------------------------------------
module fbct_front #(
   parameter int VALUE_WIDTH = fbct_pkg::VALUE_WIDTH_DEFAULT,
   localparam int CW = VALUE_WIDTH + 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_en,
   input  logic [1:0]                    load_column,
   input  logic [1:0]                    load_row,
   input  logic signed [VALUE_WIDTH-1:0] load_value,
   input  logic                          advance,
   input  logic signed [VALUE_WIDTH-1:0] box_min_x,
   input  logic signed [VALUE_WIDTH-1:0] box_min_y,
   input  logic signed [VALUE_WIDTH-1:0] box_max_x,
   input  logic signed [VALUE_WIDTH-1:0] box_max_y,
   output logic signed [VALUE_WIDTH-1:0] lo_x,
   output logic signed [VALUE_WIDTH-1:0] lo_y,
   output logic signed [VALUE_WIDTH-1:0] hi_x,
   output logic signed [VALUE_WIDTH-1:0] hi_y,
   output logic signed [CW-1:0]          nx      [fbct_pkg::NUM_PLANES],
   output logic signed [CW-1:0]          ny      [fbct_pkg::NUM_PLANES],
   output logic signed [CW-1:0]          plane_d [fbct_pkg::NUM_PLANES]
);

   logic signed [VALUE_WIDTH-1:0] mx_ff [4];
   logic signed [VALUE_WIDTH-1:0] my_ff [4];
   logic signed [VALUE_WIDTH-1:0] md_ff [4];

   logic signed [CW-1:0] nx_in      [fbct_pkg::NUM_PLANES];
   logic signed [CW-1:0] ny_in      [fbct_pkg::NUM_PLANES];
   logic signed [CW-1:0] plane_d_in [fbct_pkg::NUM_PLANES];
   logic signed [CW-1:0] nx_ff      [fbct_pkg::NUM_PLANES];
   logic signed [CW-1:0] ny_ff      [fbct_pkg::NUM_PLANES];
   logic signed [CW-1:0] plane_d_ff [fbct_pkg::NUM_PLANES];

   logic signed [VALUE_WIDTH-1:0] lo_x_ff, lo_y_ff, hi_x_ff, hi_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            mx_ff[i] <= '0;
            my_ff[i] <= '0;
            md_ff[i] <= '0;
         end
      end else if (load_en) begin
         case (load_column)
            fbct_pkg::COL_X: mx_ff[load_row] <= load_value;
            fbct_pkg::COL_Y: my_ff[load_row] <= load_value;
            fbct_pkg::COL_W: md_ff[load_row] <= load_value;
            default: ;  // drop entries of the z column
         endcase
      end
   end

   // row 3 plus or minus rows 0, 1, 2
   always_comb begin
      for (int k = 0; k < fbct_pkg::NUM_PLANES; k++) begin
         if (k % 2 == 0) begin
            nx_in[k]      = CW'(mx_ff[3]) + CW'(mx_ff[k / 2]);
            ny_in[k]      = CW'(my_ff[3]) + CW'(my_ff[k / 2]);
            plane_d_in[k] = CW'(md_ff[3]) + CW'(md_ff[k / 2]);
         end else begin
            nx_in[k]      = CW'(mx_ff[3]) - CW'(mx_ff[k / 2]);
            ny_in[k]      = CW'(my_ff[3]) - CW'(my_ff[k / 2]);
            plane_d_in[k] = CW'(md_ff[3]) - CW'(md_ff[k / 2]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lo_x_ff <= box_min_x;
         lo_y_ff <= box_min_y;
         hi_x_ff <= box_max_x;
         hi_y_ff <= box_max_y;
         for (int k = 0; k < fbct_pkg::NUM_PLANES; k++) begin
            nx_ff[k]      <= nx_in[k];
            ny_ff[k]      <= ny_in[k];
            plane_d_ff[k] <= plane_d_in[k];
         end
      end
   end

   assign lo_x    = lo_x_ff;
   assign lo_y    = lo_y_ff;
   assign hi_x    = hi_x_ff;
   assign hi_y    = hi_y_ff;
   assign nx      = nx_ff;
   assign ny      = ny_ff;
   assign plane_d = plane_d_ff;

endmodule
`default_nettype wire

[sv/fbct_mult.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Frustum box cull product stage
// Picks the p-vertex and n-vertex of each plane and forms the partial
// products of the normal with the upper and lower halves of each coordinate.
// ---------------------------------------------------------------------------
module fbct_mult #(
   parameter int VALUE_WIDTH = fbct_pkg::VALUE_WIDTH_DEFAULT,
   localparam int CW   = VALUE_WIDTH + 1,
   localparam int FRAC = VALUE_WIDTH / 2,
   localparam int HW   = VALUE_WIDTH - FRAC,
   localparam int PHW  = CW + HW,
   localparam int PLW  = CW + FRAC + 1
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic signed [VALUE_WIDTH-1:0] lo_x,
   input  logic signed [VALUE_WIDTH-1:0] lo_y,
   input  logic signed [VALUE_WIDTH-1:0] hi_x,
   input  logic signed [VALUE_WIDTH-1:0] hi_y,
   input  logic signed [CW-1:0]          nx          [fbct_pkg::NUM_PLANES],
   input  logic signed [CW-1:0]          ny          [fbct_pkg::NUM_PLANES],
   input  logic signed [CW-1:0]          plane_d     [fbct_pkg::NUM_PLANES],
   output logic signed [PHW-1:0]         xh          [fbct_pkg::NUM_TESTS],
   output logic signed [PLW-1:0]         xl          [fbct_pkg::NUM_TESTS],
   output logic signed [PHW-1:0]         yh          [fbct_pkg::NUM_TESTS],
   output logic signed [PLW-1:0]         yl          [fbct_pkg::NUM_TESTS],
   output logic signed [CW-1:0]          plane_d_out [fbct_pkg::NUM_PLANES]
);

   logic signed [VALUE_WIDTH-1:0] vx [fbct_pkg::NUM_TESTS];
   logic signed [VALUE_WIDTH-1:0] vy [fbct_pkg::NUM_TESTS];

   logic signed [PHW-1:0] xh_in [fbct_pkg::NUM_TESTS];
   logic signed [PLW-1:0] xl_in [fbct_pkg::NUM_TESTS];
   logic signed [PHW-1:0] yh_in [fbct_pkg::NUM_TESTS];
   logic signed [PLW-1:0] yl_in [fbct_pkg::NUM_TESTS];
   logic signed [PHW-1:0] xh_ff [fbct_pkg::NUM_TESTS];
   logic signed [PLW-1:0] xl_ff [fbct_pkg::NUM_TESTS];
   logic signed [PHW-1:0] yh_ff [fbct_pkg::NUM_TESTS];
   logic signed [PLW-1:0] yl_ff [fbct_pkg::NUM_TESTS];
   logic signed [CW-1:0]  plane_d_ff [fbct_pkg::NUM_PLANES];

   // even test: p-vertex, odd test: n-vertex
   always_comb begin
      for (int k = 0; k < fbct_pkg::NUM_PLANES; k++) begin
         vx[2*k]   = nx[k][CW-1] ? lo_x : hi_x;
         vx[2*k+1] = nx[k][CW-1] ? hi_x : lo_x;
         vy[2*k]   = ny[k][CW-1] ? lo_y : hi_y;
         vy[2*k+1] = ny[k][CW-1] ? hi_y : lo_y;
      end
      for (int t = 0; t < fbct_pkg::NUM_TESTS; t++) begin
         xh_in[t] = nx[t / 2] * $signed(vx[t][VALUE_WIDTH-1:FRAC]);
         xl_in[t] = nx[t / 2] * $signed({1'b0, vx[t][FRAC-1:0]});
         yh_in[t] = ny[t / 2] * $signed(vy[t][VALUE_WIDTH-1:FRAC]);
         yl_in[t] = ny[t / 2] * $signed({1'b0, vy[t][FRAC-1:0]});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int t = 0; t < fbct_pkg::NUM_TESTS; t++) begin
            xh_ff[t] <= xh_in[t];
            xl_ff[t] <= xl_in[t];
            yh_ff[t] <= yh_in[t];
            yl_ff[t] <= yl_in[t];
         end
         for (int k = 0; k < fbct_pkg::NUM_PLANES; k++) begin
            plane_d_ff[k] <= plane_d[k];
         end
      end
   end

   assign xh          = xh_ff;
   assign xl          = xl_ff;
   assign yh          = yh_ff;
   assign yl          = yl_ff;
   assign plane_d_out = plane_d_ff;

endmodule
`default_nettype wire

[sv/fbct_sum.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// Frustum box cull sum stages
// Joins the partial products into exact plane terms, adds the scaled
// distance and keeps the sign of each plane test.
// ---------------------------------------------------------------------------
module fbct_sum #(
   parameter int VALUE_WIDTH = fbct_pkg::VALUE_WIDTH_DEFAULT,
   localparam int CW   = VALUE_WIDTH + 1,
   localparam int FRAC = VALUE_WIDTH / 2,
   localparam int HW   = VALUE_WIDTH - FRAC,
   localparam int PHW  = CW + HW,
   localparam int PLW  = CW + FRAC + 1,
   localparam int TW   = 2 * VALUE_WIDTH + 1,
   localparam int AW   = 2 * VALUE_WIDTH + 3
) (
   input  logic                                clock,
   input  logic                                advance_join,
   input  logic                                advance_sign,
   input  logic signed [PHW-1:0]               xh      [fbct_pkg::NUM_TESTS],
   input  logic signed [PLW-1:0]               xl      [fbct_pkg::NUM_TESTS],
   input  logic signed [PHW-1:0]               yh      [fbct_pkg::NUM_TESTS],
   input  logic signed [PLW-1:0]               yl      [fbct_pkg::NUM_TESTS],
   input  logic signed [CW-1:0]                plane_d [fbct_pkg::NUM_PLANES],
   output logic [fbct_pkg::NUM_TESTS-1:0]      neg
);

   logic signed [TW-1:0] sx_in [fbct_pkg::NUM_TESTS];
   logic signed [TW-1:0] sy_in [fbct_pkg::NUM_TESTS];
   logic signed [TW-1:0] sx_ff [fbct_pkg::NUM_TESTS];
   logic signed [TW-1:0] sy_ff [fbct_pkg::NUM_TESTS];
   logic signed [CW-1:0] plane_d_ff [fbct_pkg::NUM_PLANES];
   logic signed [AW-1:0] acc [fbct_pkg::NUM_TESTS];
   logic [fbct_pkg::NUM_TESTS-1:0] neg_in;
   logic [fbct_pkg::NUM_TESTS-1:0] neg_ff;

   always_comb begin
      for (int t = 0; t < fbct_pkg::NUM_TESTS; t++) begin
         sx_in[t] = (TW'(xh[t]) <<< FRAC) + TW'(xl[t]);
         sy_in[t] = (TW'(yh[t]) <<< FRAC) + TW'(yl[t]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance_join) begin
         for (int t = 0; t < fbct_pkg::NUM_TESTS; t++) begin
            sx_ff[t] <= sx_in[t];
            sy_ff[t] <= sy_in[t];
         end
         for (int k = 0; k < fbct_pkg::NUM_PLANES; k++) begin
            plane_d_ff[k] <= plane_d[k];
         end
      end
   end

   always_comb begin
      for (int t = 0; t < fbct_pkg::NUM_TESTS; t++) begin
         acc[t]    = AW'(sx_ff[t]) + AW'(sy_ff[t]) + (AW'(plane_d_ff[t / 2]) <<< FRAC);
         neg_in[t] = acc[t][AW-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance_sign) begin
         neg_ff <= neg_in;
      end
   end

   assign neg = neg_ff;

endmodule
`default_nettype wire
